### hdl/hpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
package hpq_pkg;

	// Operation codes carried on cmd.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} hpq_status_t;

	// Per-cycle control broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic rem;
	} hpq_ctl_t;

endpackage

### hdl/hpq_cell.sv
// One slot of the sorted cell chain: holds a value and shifts with its neighbors.
module hpq_cell #(
	parameter int VALUE_WIDTH = 32,
	parameter int CNT_W       = 7,
	parameter int CELL_IDX    = 0
) (
	input  logic                          clk,
	input  hpq_pkg::hpq_ctl_t             ctl,
	input  logic [CNT_W-1:0]              count,
	input  logic signed [VALUE_WIDTH-1:0] new_value,
	input  logic signed [VALUE_WIDTH-1:0] prev_value,
	input  logic                          prev_gt,
	input  logic signed [VALUE_WIDTH-1:0] next_value,
	output logic signed [VALUE_WIDTH-1:0] cur_value,
	output logic                          gt
);
	import hpq_pkg::*;

	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          occ;

	// Slot holds a live entry when it sits below the fill count.
	assign occ       = count > CNT_W'(CELL_IDX);
	// New value ranks ahead of this slot: empty slot or strictly smaller entry.
	assign gt        = !occ || (new_value > val_q);
	assign cur_value = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && gt) begin
			// Upstream neighbor also displaced: take its value, else the new one.
			val_q <= prev_gt ? prev_value : new_value;
		end else if (ctl.rem) begin
			val_q <= next_value;
		end
	end

endmodule

### hdl/max_heap_priority_queue.sv
// Top level of the max priority queue: cell chain, fill count and result register.
//
// Priority queue of signed values with max-first removal. Entries live in a
// chain of HEAP_DEPTH cells kept sorted in descending order, cell 0 holding the
// maximum. An insert beat compares its value against every cell at once; cells
// at and behind the insertion point shift one place down the chain. A remove
// beat returns cell 0 and shifts every cell one place up. Each accepted input
// beat yields exactly one result beat in the cycle after it is accepted. A
// one-deep result register decouples the two channels: a new input beat is
// taken whenever that register is empty or is being drained in the same
// cycle. Results carry the removed value (zero on inserts and failed removes),
// a status (ok, remove on empty, insert on full dropped) and the entry count
// after the beat. There is no clearing pass after reset; only the fill count
// is cleared, and slots beyond it are never read.
module max_heap_priority_queue #(
	parameter int HEAP_DEPTH  = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic signed [VALUE_WIDTH-1:0] value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] popped_value,
	output hpq_pkg::hpq_status_t          status,
	output logic [CNT_W-1:0]              entry_count
);
	import hpq_pkg::*;

	logic                          accept;
	logic                          is_ins;
	logic                          full;
	logic                          empty;
	hpq_ctl_t                      ctl;
	logic [CNT_W-1:0]              count_q;

	logic signed [VALUE_WIDTH-1:0] cell_val [HEAP_DEPTH];
	logic                          cell_gt  [HEAP_DEPTH];

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] popped_value_q;
	hpq_status_t                   status_q;
	logic [CNT_W-1:0]              entry_count_q;

	// Take a beat when the result register is free or emptying this cycle.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign is_ins = (cmd == CMD_INSERT);
	assign full   = (count_q == CNT_W'(HEAP_DEPTH));
	assign empty  = (count_q == '0);

	// Cells move only on beats that change the contents.
	assign ctl.ins = accept && is_ins && !full;
	assign ctl.rem = accept && !is_ins && !empty;

	// Cell chain: each slot looks at its upstream neighbor for inserts and its
	// downstream neighbor for removes. Chain ends are tied off.
	for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] prev_v;
		logic                          prev_g;
		logic signed [VALUE_WIDTH-1:0] next_v;

		if (i == 0) begin : g_head
			assign prev_v = value;
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_v = cell_val[i-1];
			assign prev_g = cell_gt[i-1];
		end

		if (i == HEAP_DEPTH - 1) begin : g_tail
			assign next_v = cell_val[i];
		end else begin : g_mid
			assign next_v = cell_val[i+1];
		end

		hpq_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.CNT_W       (CNT_W),
			.CELL_IDX    (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.new_value  (value),
			.prev_value (prev_v),
			.prev_gt    (prev_g),
			.next_value (next_v),
			.cur_value  (cell_val[i]),
			.gt         (cell_gt[i])
		);
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded on each accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_ins) begin
				popped_value_q <= '0;
				status_q       <= full ? ST_FULL : ST_OK;
				entry_count_q  <= full ? count_q : count_q + CNT_W'(1);
			end else begin
				popped_value_q <= empty ? '0 : cell_val[0];
				status_q       <= empty ? ST_EMPTY : ST_OK;
				entry_count_q  <= empty ? count_q : count_q - CNT_W'(1);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_value_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;

endmodule
